// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define JPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("jps assertion failed");
// checked on every edge, reset included
`define JPS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("jps assertion failed");
`else
`define JPS_ASSERT(lbl, prop)
`define JPS_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== design/jps_pkg.sv =====
// ----------------------------------------------------------------------------
// jps_pkg
// Types, constants and direction helpers of the jump point successor block.
// ----------------------------------------------------------------------------
package jps_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int GRID_LIM   = 256;   // 8-bit coordinates
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int LIM_W      = (MAX_WIDTH  < GRID_LIM) ? MAX_WIDTH  : GRID_LIM;
  localparam int LIM_H      = (MAX_HEIGHT < GRID_LIM) ? MAX_HEIGHT : GRID_LIM;
  localparam int CRD_W      = 10;    // signed, covers one cell beyond each edge
  localparam int G_W        = 24;
  localparam int FETCH_N    = 4;     // cells read per probe

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic signed [1:0]       step_t;

  typedef enum logic [2:0] {
    DIR_R, DIR_DR, DIR_D, DIR_DL, DIR_L, DIR_UL, DIR_U, DIR_UR
  } dir_t;

  typedef enum logic [2:0] {
    REG_GRID_W, REG_GRID_H, REG_GOAL_X, REG_GOAL_Y, REG_STRAIGHT, REG_DIAG
  } reg_idx_t;

  typedef enum logic {KIND_WRITE, KIND_EXPAND} kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WRD, ST_WWR, ST_START, ST_DIR, ST_FETCH, ST_EVAL,
    ST_COST1, ST_COST2, ST_PUSH, ST_FIN
  } state_t;

  typedef enum logic [2:0] {PH_PRUNE, PH_MAIN, PH_DIAG, PH_PROBE_H, PH_PROBE_V} phase_t;

  typedef enum logic {FK_STEP, FK_FORCE} fkind_t;

  typedef struct packed {
    logic [8:0] use_w;
    logic [8:0] use_h;
    logic [7:0] goal_x;
    logic [7:0] goal_y;
    logic [7:0] straight_cost;
    logic [7:0] diagonal_cost;
  } cfg_t;

  typedef struct packed {
    logic           valid;
    logic           found;
    logic [7:0]     x;
    logic [7:0]     y;
    logic [G_W-1:0] g;
    logic           last;
  } emit_t;

  function automatic step_t dir_dx(dir_t d);
    step_t s;
    case (d)
      DIR_R, DIR_DR, DIR_UR: s = 2'sd1;
      DIR_DL, DIR_L, DIR_UL: s = -2'sd1;
      default:               s = 2'sd0;
    endcase
    return s;
  endfunction

  function automatic step_t dir_dy(dir_t d);
    step_t s;
    case (d)
      DIR_DR, DIR_D, DIR_DL: s = 2'sd1;
      DIR_UL, DIR_U, DIR_UR: s = -2'sd1;
      default:               s = 2'sd0;
    endcase
    return s;
  endfunction

  function automatic dir_t dir_of(step_t dx, step_t dy);
    dir_t d;
    case ({dx, dy})
      {2'sd1,  2'sd0}:  d = DIR_R;
      {2'sd1,  2'sd1}:  d = DIR_DR;
      {2'sd0,  2'sd1}:  d = DIR_D;
      {-2'sd1, 2'sd1}:  d = DIR_DL;
      {-2'sd1, 2'sd0}:  d = DIR_L;
      {-2'sd1, -2'sd1}: d = DIR_UL;
      {2'sd0,  -2'sd1}: d = DIR_U;
      {2'sd1,  -2'sd1}: d = DIR_UR;
      default:          d = DIR_R;
    endcase
    return d;
  endfunction

endpackage

// ===== design/jps_in_if.sv =====
// ----------------------------------------------------------------------------
// jps_in_if
// Request channel: grid cell writes and node expansions.
// ----------------------------------------------------------------------------
interface jps_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  node_x;
  logic [7:0]  node_y;
  logic        wall;
  logic [23:0] node_g;
  logic        has_parent;
  logic [7:0]  parent_x;
  logic [7:0]  parent_y;

  modport source (output valid, kind, node_x, node_y, wall, node_g, has_parent,
                  parent_x, parent_y, input ready);
  modport sink   (input valid, kind, node_x, node_y, wall, node_g, has_parent,
                  parent_x, parent_y, output ready);
endinterface

// ===== design/jps_out_if.sv =====
// ----------------------------------------------------------------------------
// jps_out_if
// Result channel: the jump points of each expansion (or a not-found marker), last on the final one.
// ----------------------------------------------------------------------------
interface jps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [7:0]  jump_x;
  logic [7:0]  jump_y;
  logic [23:0] jump_g;
  logic        last;

  modport source (output valid, found, jump_x, jump_y, jump_g, last, input ready);
  modport sink   (input valid, found, jump_x, jump_y, jump_g, last, output ready);
endinterface

// ===== design/jps_cfg_if.sv =====
// ----------------------------------------------------------------------------
// jps_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface jps_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/jps_ram.sv =====
// ----------------------------------------------------------------------------
// jps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module jps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/jps_cfg.sv =====
// ----------------------------------------------------------------------------
// jps_cfg
// Configuration registers and the clamped grid size in use.
// ----------------------------------------------------------------------------
module jps_cfg import jps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  jps_cfg_if.sink   cfg_ch,
  output cfg_t      cfg
);

  logic [8:0] grid_w_r, grid_h_r;
  logic [7:0] goal_x_r, goal_y_r, straight_r, diag_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r   <= 9'd256;
      grid_h_r   <= 9'd256;
      goal_x_r   <= 8'd0;
      goal_y_r   <= 8'd0;
      straight_r <= 8'd10;
      diag_r     <= 8'd14;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_GRID_W:   grid_w_r   <= cfg_ch.data;
        REG_GRID_H:   grid_h_r   <= cfg_ch.data;
        REG_GOAL_X:   goal_x_r   <= cfg_ch.data[7:0];
        REG_GOAL_Y:   goal_y_r   <= cfg_ch.data[7:0];
        REG_STRAIGHT: straight_r <= cfg_ch.data[7:0];
        REG_DIAG:     diag_r     <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.use_w         = (grid_w_r > 9'(LIM_W)) ? 9'(LIM_W) : grid_w_r;
    cfg.use_h         = (grid_h_r > 9'(LIM_H)) ? 9'(LIM_H) : grid_h_r;
    cfg.goal_x        = goal_x_r;
    cfg.goal_y        = goal_y_r;
    cfg.straight_cost = straight_r;
    cfg.diagonal_cost = diag_r;
  end

endmodule

// ===== design/jps_ctrl.sv =====
// ----------------------------------------------------------------------------
// jps_ctrl
// Sequencer: wall map clear and cell writes, pruning, jump walks, cost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jps_ctrl import jps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  jps_in_if.sink               in_ch,
  input  cfg_t                 cfg,
  input  logic                 out_free,
  output emit_t                emit,
  output logic                 mem_we,
  output logic [ROW_W-1:0]     mem_waddr,
  output logic [MAX_WIDTH-1:0] mem_wdata,
  output logic                 mem_re,
  output logic [ROW_W-1:0]     mem_raddr,
  input  logic [MAX_WIDTH-1:0] mem_rdata
);

  state_t state_r, state_nxt;
  logic [ROW_W-1:0] clr_r, clr_nxt;

  logic [7:0]     node_x_r, node_y_r, node_x_nxt, node_y_nxt;
  logic [G_W-1:0] g_r, g_nxt;
  logic           wall_r, wall_nxt, has_par_r, has_par_nxt;
  step_t          adx_r, ady_r, adx_nxt, ady_nxt;

  dir_t       list_r [8];
  dir_t       list_nxt [8];
  logic [3:0] lcnt_r, lcnt_nxt, lidx_r, lidx_nxt;

  phase_t phase_r, phase_nxt;
  crd_t   px_r, py_r, px_nxt, py_nxt, dpx_r, dpy_r, dpx_nxt, dpy_nxt;
  step_t  dx_r, dy_r, dx_nxt, dy_nxt, ddx_r, ddy_r, ddx_nxt, ddy_nxt;

  fkind_t             fkind_r, fkind_nxt;
  logic [2:0]         fk_r, fk_nxt;
  logic [FETCH_N-1:0] cells_r;
  logic               rd_vld_r, rd_inb_r;
  logic [1:0]         rd_idx_r;
  logic [COL_W-1:0]   rd_col_r;

  logic [7:0]     jx_r, jy_r, jx_nxt, jy_nxt;
  logic [15:0]    p1_r, p2_r;
  logic [G_W-1:0] res_g_r;
  logic           pend_vld_r, pend_vld_nxt;
  logic [7:0]     pend_x_r, pend_y_r;
  logic [G_W-1:0] pend_g_r;
  logic           pend_load;

  // ---- probe geometry
  crd_t  bx, by, fx, fy, nx_c, ny_c, newx, newy, gx, gy;
  step_t bdx, bdy;
  logic  is_diag, step_ok, forced, at_goal, inb, accept;
  crd_t  cx [FETCH_N];
  crd_t  cy [FETCH_N];

  assign accept = in_ch.valid && in_ch.ready;
  assign nx_c   = crd_t'(node_x_r);
  assign ny_c   = crd_t'(node_y_r);
  assign gx     = crd_t'(cfg.goal_x);
  assign gy     = crd_t'(cfg.goal_y);

  always_comb begin
    bx  = (phase_r == PH_DIAG) ? dpx_r : px_r;
    by  = (phase_r == PH_DIAG) ? dpy_r : py_r;
    bdx = (phase_r == PH_DIAG) ? ddx_r : dx_r;
    bdy = (phase_r == PH_DIAG) ? ddy_r : dy_r;
    if (fkind_r == FK_STEP) begin
      cx[0] = bx + crd_t'(bdx); cy[0] = by + crd_t'(bdy);
      cx[1] = bx + crd_t'(bdx); cy[1] = by;
      cx[2] = bx;               cy[2] = by + crd_t'(bdy);
      cx[3] = cx[0];            cy[3] = cy[0];
    end else if (bdx != 2'sd0) begin
      cx[0] = bx - crd_t'(bdx); cy[0] = by + crd_t'(1);
      cx[1] = bx;               cy[1] = by + crd_t'(1);
      cx[2] = bx - crd_t'(bdx); cy[2] = by - crd_t'(1);
      cx[3] = bx;               cy[3] = by - crd_t'(1);
    end else begin
      cx[0] = bx + crd_t'(1);   cy[0] = by - crd_t'(bdy);
      cx[1] = bx + crd_t'(1);   cy[1] = by;
      cx[2] = bx - crd_t'(1);   cy[2] = by - crd_t'(bdy);
      cx[3] = bx - crd_t'(1);   cy[3] = by;
    end
    fx = cx[fk_r[1:0]];
    fy = cy[fk_r[1:0]];
    inb = (fx >= crd_t'(0)) && (fy >= crd_t'(0)) &&
          (fx < crd_t'(cfg.use_w)) && (fy < crd_t'(cfg.use_h));
    is_diag = (bdx != 2'sd0) && (bdy != 2'sd0);
    step_ok = cells_r[0] & (~is_diag | (cells_r[1] & cells_r[2]));
    forced  = (~cells_r[0] & cells_r[1]) | (~cells_r[2] & cells_r[3]);
    newx    = bx + crd_t'(bdx);
    newy    = by + crd_t'(bdy);
    at_goal = (newx == gx) && (newy == gy);
  end

  // ---- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == ROW_W'(MAX_HEIGHT - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (kind_t'(in_ch.kind) == KIND_EXPAND) begin
            state_nxt = ST_START;
          end else if (int'(in_ch.node_x) < MAX_WIDTH &&
                       int'(in_ch.node_y) < MAX_HEIGHT) begin
            state_nxt = ST_WRD;
          end
        end
      end
      ST_WRD: state_nxt = ST_WWR;
      ST_WWR: state_nxt = ST_IDLE;
      ST_START: begin
        if (!has_par_r || (adx_r == 2'sd0 && ady_r == 2'sd0) ||
            (adx_r != 2'sd0 && ady_r != 2'sd0)) begin
          state_nxt = ST_DIR;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_DIR:   state_nxt = (lidx_r < lcnt_r) ? ST_FETCH : ST_FIN;
      ST_FETCH: if (fk_r == 3'(FETCH_N)) state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (fkind_r == FK_FORCE) begin
          if (phase_r == PH_PRUNE) state_nxt = ST_DIR;
          else state_nxt = forced ? ST_COST1 : ST_FETCH;
        end else if (!step_ok) begin
          state_nxt = (phase_r == PH_MAIN || phase_r == PH_DIAG) ? ST_DIR : ST_FETCH;
        end else begin
          state_nxt = at_goal ? ST_COST1 : ST_FETCH;
        end
      end
      ST_COST1: state_nxt = ST_COST2;
      ST_COST2: state_nxt = ST_PUSH;
      ST_PUSH:  if (!pend_vld_r || out_free) state_nxt = ST_DIR;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---- outputs
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    mem_we      = 1'b0;
    mem_waddr   = clr_r;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = fy[ROW_W-1:0];
    emit        = '0;
    pend_load   = 1'b0;
    unique case (state_r)
      ST_CLEAR: mem_we = 1'b1;
      ST_WRD: begin
        mem_re    = 1'b1;
        mem_raddr = ROW_W'(node_y_r);
      end
      ST_WWR: begin
        mem_we    = 1'b1;
        mem_waddr = ROW_W'(node_y_r);
        mem_wdata = mem_rdata;
        mem_wdata[COL_W'(node_x_r)] = wall_r;
      end
      ST_FETCH: mem_re = (fk_r < 3'(FETCH_N));
      ST_PUSH: begin
        if (pend_vld_r && out_free) begin
          emit = '{valid: 1'b1, found: 1'b1, x: pend_x_r, y: pend_y_r,
                   g: pend_g_r, last: 1'b0};
        end
        pend_load = !pend_vld_r || out_free;
      end
      ST_FIN: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.last  = 1'b1;
          if (pend_vld_r) begin
            emit.found = 1'b1;
            emit.x     = pend_x_r;
            emit.y     = pend_y_r;
            emit.g     = pend_g_r;
          end
        end
      end
      default: ;
    endcase
  end

  // ---- datapath next values
  always_comb begin
    clr_nxt      = clr_r;
    node_x_nxt   = node_x_r;
    node_y_nxt   = node_y_r;
    g_nxt        = g_r;
    wall_nxt     = wall_r;
    has_par_nxt  = has_par_r;
    adx_nxt      = adx_r;
    ady_nxt      = ady_r;
    list_nxt     = list_r;
    lcnt_nxt     = lcnt_r;
    lidx_nxt     = lidx_r;
    phase_nxt    = phase_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    dpx_nxt      = dpx_r;
    dpy_nxt      = dpy_r;
    ddx_nxt      = ddx_r;
    ddy_nxt      = ddy_r;
    fkind_nxt    = fkind_r;
    fk_nxt       = fk_r;
    jx_nxt       = jx_r;
    jy_nxt       = jy_r;
    pend_vld_nxt = pend_vld_r;

    unique case (state_r)
      ST_CLEAR: clr_nxt = clr_r + 1'b1;
      ST_IDLE: begin
        if (accept) begin
          node_x_nxt   = in_ch.node_x;
          node_y_nxt   = in_ch.node_y;
          g_nxt        = in_ch.node_g;
          wall_nxt     = in_ch.wall;
          has_par_nxt  = in_ch.has_parent;
          adx_nxt      = (in_ch.node_x > in_ch.parent_x) ? 2'sd1 :
                         (in_ch.node_x < in_ch.parent_x) ? -2'sd1 : 2'sd0;
          ady_nxt      = (in_ch.node_y > in_ch.parent_y) ? 2'sd1 :
                         (in_ch.node_y < in_ch.parent_y) ? -2'sd1 : 2'sd0;
          pend_vld_nxt = 1'b0;
        end
      end
      ST_START: begin
        lidx_nxt = 4'd0;
        if (!has_par_r || (adx_r == 2'sd0 && ady_r == 2'sd0)) begin
          for (int i = 0; i < 8; i++) list_nxt[i] = dir_t'(i);
          lcnt_nxt = 4'd8;
        end else if (adx_r != 2'sd0 && ady_r != 2'sd0) begin
          list_nxt[0] = dir_of(adx_r, 2'sd0);
          list_nxt[1] = dir_of(2'sd0, ady_r);
          list_nxt[2] = dir_of(adx_r, ady_r);
          lcnt_nxt    = 4'd3;
        end else begin
          // straight arrival: fetch the forced-neighbor cells around the node
          phase_nxt = PH_PRUNE;
          px_nxt    = nx_c;
          py_nxt    = ny_c;
          dx_nxt    = adx_r;
          dy_nxt    = ady_r;
          fkind_nxt = FK_FORCE;
          fk_nxt    = 3'd0;
        end
      end
      ST_DIR: begin
        if (lidx_r < lcnt_r) begin
          lidx_nxt  = lidx_r + 1'b1;
          fkind_nxt = FK_STEP;
          fk_nxt    = 3'd0;
          if (dir_dx(list_r[lidx_r[2:0]]) != 2'sd0 &&
              dir_dy(list_r[lidx_r[2:0]]) != 2'sd0) begin
            phase_nxt = PH_DIAG;
            dpx_nxt   = nx_c;
            dpy_nxt   = ny_c;
            ddx_nxt   = dir_dx(list_r[lidx_r[2:0]]);
            ddy_nxt   = dir_dy(list_r[lidx_r[2:0]]);
          end else begin
            phase_nxt = PH_MAIN;
            px_nxt    = nx_c;
            py_nxt    = ny_c;
            dx_nxt    = dir_dx(list_r[lidx_r[2:0]]);
            dy_nxt    = dir_dy(list_r[lidx_r[2:0]]);
          end
        end
      end
      ST_FETCH: if (fk_r < 3'(FETCH_N)) fk_nxt = fk_r + 1'b1;
      ST_EVAL: begin
        fk_nxt = 3'd0;
        if (fkind_r == FK_FORCE) begin
          if (phase_r == PH_PRUNE) begin
            // natural direction, then each forced pair in order
            lidx_nxt = 4'd0;
            if (dx_r != 2'sd0) begin
              list_nxt[0] = dir_of(dx_r, 2'sd0);
              if (forced) begin
                list_nxt[1] = (~cells_r[0] & cells_r[1]) ? DIR_D : DIR_U;
                list_nxt[2] = (~cells_r[0] & cells_r[1]) ? dir_of(dx_r, 2'sd1)
                                                          : dir_of(dx_r, -2'sd1);
              end
              list_nxt[3] = DIR_U;
              list_nxt[4] = dir_of(dx_r, -2'sd1);
            end else begin
              list_nxt[0] = dir_of(2'sd0, dy_r);
              if (forced) begin
                list_nxt[1] = (~cells_r[0] & cells_r[1]) ? DIR_R : DIR_L;
                list_nxt[2] = (~cells_r[0] & cells_r[1]) ? dir_of(2'sd1, dy_r)
                                                          : dir_of(-2'sd1, dy_r);
              end
              list_nxt[3] = DIR_L;
              list_nxt[4] = dir_of(-2'sd1, dy_r);
            end
            lcnt_nxt = 4'd1 + {2'd0, (~cells_r[0] & cells_r[1]), 1'b0} +
                       {2'd0, (~cells_r[2] & cells_r[3]), 1'b0};
          end else if (forced) begin
            jx_nxt = (phase_r == PH_MAIN) ? px_r[7:0] : dpx_r[7:0];
            jy_nxt = (phase_r == PH_MAIN) ? py_r[7:0] : dpy_r[7:0];
          end else begin
            fkind_nxt = FK_STEP;
          end
        end else if (!step_ok) begin
          if (phase_r == PH_PROBE_H) begin
            phase_nxt = PH_PROBE_V;
            px_nxt    = dpx_r;
            py_nxt    = dpy_r;
            dx_nxt    = 2'sd0;
            dy_nxt    = ddy_r;
          end else if (phase_r == PH_PROBE_V) begin
            phase_nxt = PH_DIAG;
          end
        end else begin
          if (phase_r == PH_DIAG) begin
            dpx_nxt = newx;
            dpy_nxt = newy;
          end else begin
            px_nxt = newx;
            py_nxt = newy;
          end
          if (at_goal) begin
            jx_nxt = (phase_r == PH_MAIN || phase_r == PH_DIAG) ? newx[7:0] : dpx_r[7:0];
            jy_nxt = (phase_r == PH_MAIN || phase_r == PH_DIAG) ? newy[7:0] : dpy_r[7:0];
          end else if (phase_r == PH_DIAG) begin
            phase_nxt = PH_PROBE_H;
            px_nxt    = newx;
            py_nxt    = newy;
            dx_nxt    = ddx_r;
            dy_nxt    = 2'sd0;
          end else begin
            fkind_nxt = FK_FORCE;
          end
        end
      end
      ST_PUSH: if (pend_load) pend_vld_nxt = 1'b1;
      default: ;
    endcase
  end

  // ---- cost
  logic [7:0]  ax, ay, hi, lo;
  logic [G_W:0] total;

  always_comb begin
    ax    = (jx_r > node_x_r) ? (jx_r - node_x_r) : (node_x_r - jx_r);
    ay    = (jy_r > node_y_r) ? (jy_r - node_y_r) : (node_y_r - jy_r);
    hi    = (ax > ay) ? ax : ay;
    lo    = (ax > ay) ? ay : ax;
    total = {1'b0, g_r} + (G_W+1)'(p1_r) + (G_W+1)'(p2_r);
  end

  // ---- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      fk_r       <= '0;
      rd_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      fk_r       <= fk_nxt;
      rd_vld_r   <= (state_r == ST_FETCH) && (fk_r < 3'(FETCH_N));
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_x_r  <= node_x_nxt;
    node_y_r  <= node_y_nxt;
    g_r       <= g_nxt;
    wall_r    <= wall_nxt;
    has_par_r <= has_par_nxt;
    adx_r     <= adx_nxt;
    ady_r     <= ady_nxt;
    list_r    <= list_nxt;
    lcnt_r    <= lcnt_nxt;
    lidx_r    <= lidx_nxt;
    phase_r   <= phase_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    dpx_r     <= dpx_nxt;
    dpy_r     <= dpy_nxt;
    ddx_r     <= ddx_nxt;
    ddy_r     <= ddy_nxt;
    fkind_r   <= fkind_nxt;
    jx_r      <= jx_nxt;
    jy_r      <= jy_nxt;
    rd_idx_r  <= fk_r[1:0];
    rd_inb_r  <= inb;
    rd_col_r  <= fx[COL_W-1:0];
    if (rd_vld_r) begin
      cells_r[rd_idx_r] <= rd_inb_r & ~mem_rdata[rd_col_r];
    end
    if (state_r == ST_COST1) begin
      p1_r <= cfg.straight_cost * (hi - lo);
      p2_r <= cfg.diagonal_cost * lo;
    end
    if (state_r == ST_COST2) begin
      res_g_r <= total[G_W] ? '1 : total[G_W-1:0];
    end
    if (pend_load) begin
      pend_x_r <= jx_r;
      pend_y_r <= jy_r;
      pend_g_r <= res_g_r;
    end
  end

  `JPS_ASSERT(a_emit_room, emit.valid |-> out_free)
  `JPS_ASSERT(a_fetch_bound, fk_r <= 3'(FETCH_N))
  `JPS_ASSERT(a_capture_after_issue, rd_vld_r |-> $past(state_r == ST_FETCH))
  `JPS_ASSERT_RST(a_reset_quiet, !rst_n |=> (state_r == ST_CLEAR && !emit.valid))

endmodule

// ===== design/jump_point_successors.sv =====
// ----------------------------------------------------------------------------
// jump_point_successors
// Jump point successor generator on a wall bitmap, no corner cutting.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  in_ch    in   cell write (kind 0) or node expansion request (kind 1)
//  out_ch   out  jump point per result, last marks end of an expansion
//  cfg_ch   in   register index + data, always ready
//
//  A cell write runs through accept, row read and modified row write back.
//  Each probe reads four cells through the single map read port, then
//  evaluates them. A straight step takes a step probe and a forced-neighbor
//  probe, a diagonal step one probe plus its two straight scans; each
//  direction tried adds a direction state and each result passes cost,
//  cost and push. Run time follows the grid content.
//  After reset the map is swept free, one row per cycle, with in_ch not
//  ready.  A full output register stalls the sequencer.
// ----------------------------------------------------------------------------
module jump_point_successors import jps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  jps_in_if.sink    in_ch,
  jps_out_if.source out_ch,
  jps_cfg_if.sink   cfg_ch
);

  cfg_t  cfg;
  emit_t emit;
  logic  out_free;

  logic                 mem_we, mem_re;
  logic [ROW_W-1:0]     mem_waddr, mem_raddr;
  logic [MAX_WIDTH-1:0] mem_wdata, mem_rdata;

  // output register
  logic        out_vld_r;
  logic        found_r, last_r;
  logic [7:0]  jx_r, jy_r;
  logic [23:0] jg_r;

  jps_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // wall map: one row of cells per word
  jps_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  jps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .out_free  (out_free),
    .emit      (emit),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // slot is free when empty or draining this cycle
  assign out_free = !out_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit.valid) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      found_r <= emit.found;
      jx_r    <= emit.x;
      jy_r    <= emit.y;
      jg_r    <= emit.g;
      last_r  <= emit.last;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.found  = found_r;
  assign out_ch.jump_x = jx_r;
  assign out_ch.jump_y = jy_r;
  assign out_ch.jump_g = jg_r;
  assign out_ch.last   = last_r;

endmodule
